>>> rtl/uart_8n1_transceiver_defines.svh
// ---------------------------------------------------------------------------
// uart_8n1_transceiver_defines.svh
// Assertion macros shared by the checker of the 8N1 transceiver.
// ---------------------------------------------------------------------------
`ifndef UART_8N1_TRANSCEIVER_DEFINES_SVH
`define UART_8N1_TRANSCEIVER_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define U8N1_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, clocked on i_clk, off during reset
`define U8N1_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/u8n1_pkg.sv
// ---------------------------------------------------------------------------
// u8n1_pkg
// Types and constants of the 8N1 serial transceiver.
// ---------------------------------------------------------------------------
`default_nettype none

package u8n1_pkg;

    localparam int BYTE_W    = 8;
    localparam int TPB_W     = 16;
    localparam int TMO_W     = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIMEOUT = 1'd1;

    localparam logic [TPB_W-1:0] TPB_RESET   = 16'd104;
    localparam logic [TMO_W-1:0] WAIT_SAT    = 24'hFFFFFF;

    // transmit phases: idle, start bit, data bits, stop bit
    localparam logic [3:0] TX_IDLE      = 4'd0;
    localparam logic [3:0] TX_START     = 4'd1;
    localparam logic [3:0] TX_FIRST_BIT = 4'd2;
    localparam logic [3:0] TX_STOP      = 4'd10;

    typedef struct packed {
        logic              line_out;
        logic              sender_busy;
        logic              got_byte;
        logic [BYTE_W-1:0] received_byte;
        logic              timed_out;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/uart_8n1_transceiver.sv
// ---------------------------------------------------------------------------
// uart_8n1_transceiver
// 8N1 serial transmitter and receiver advanced by one sample tick per item.
// ---------------------------------------------------------------------------
// Each input transaction is one sample tick and yields exactly one result
// transaction. The block takes one tick per clock cycle while not stalled: the
// bit timers, phase counter and receive shifter update in a single pass between
// the state registers and the result register, which is the output register or,
// while that holds an unaccepted result, the skid register. The two registers
// decouple the two sides; the input is stalled only while both hold results.
// ---------------------------------------------------------------------------
`default_nettype none

module uart_8n1_transceiver (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [u8n1_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [u8n1_pkg::CFG_W-1:0]        i_cfg_data,
    // input channel
    input  wire logic                              i_in_valid,
    output      logic                              o_in_stall,
    input  wire logic                              i_line_in,
    input  wire logic                              i_send_request,
    input  wire logic [u8n1_pkg::BYTE_W-1:0]       i_send_byte,
    input  wire logic                              i_arm_receive,
    // output channel
    output      logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    output      logic                              o_line_out,
    output      logic                              o_sender_busy,
    output      logic                              o_got_byte,
    output      logic [u8n1_pkg::BYTE_W-1:0]       o_received_byte,
    output      logic                              o_timed_out
);

    typedef enum logic [1:0] {
        RX_IDLE = 2'd0,
        RX_WAIT = 2'd1,
        RX_DATA = 2'd2,
        RX_STOP = 2'd3
    } t_rx_mode;

    // configuration
    logic [u8n1_pkg::TPB_W-1:0]  r_tpb;
    logic [u8n1_pkg::TMO_W-1:0]  r_timeout;

    // transmit state
    logic [u8n1_pkg::BYTE_W-1:0] r_tx_shift, n_tx_shift;
    logic [3:0]                  r_tx_phase, n_tx_phase;
    logic [u8n1_pkg::TPB_W-1:0]  r_tx_timer, n_tx_timer;

    // receive state
    t_rx_mode                    r_rx_mode, n_rx_mode;
    logic [u8n1_pkg::TPB_W-1:0]  r_rx_timer, n_rx_timer;
    logic [3:0]                  r_rx_bit_count, n_rx_bit_count;
    logic [u8n1_pkg::BYTE_W-1:0] r_rx_shift, n_rx_shift;
    logic [u8n1_pkg::TMO_W-1:0]  r_wait_count, n_wait_count;

    // result buffering
    u8n1_pkg::t_result           r_out, r_skid, n_res;
    logic                        r_out_valid, r_skid_valid;

    logic                        in_take, out_take;
    logic [u8n1_pkg::TPB_W:0]    tx_tick, rx_tick, rx_limit;
    logic [3:0]                  tx_idx, rx_idx;

    assign in_take  = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;

    // ---------------- transmitter ----------------
    always_comb begin
        n_tx_shift = r_tx_shift;
        n_tx_phase = r_tx_phase;
        n_tx_timer = r_tx_timer;
        n_res      = '0;
        tx_tick    = '0;
        tx_idx     = '0;

        if (r_tx_phase == u8n1_pkg::TX_IDLE && i_send_request) begin
            n_tx_shift = i_send_byte;
            n_tx_phase = u8n1_pkg::TX_START;
            n_tx_timer = '0;
        end

        tx_idx = n_tx_phase - u8n1_pkg::TX_FIRST_BIT;
        if (n_tx_phase == u8n1_pkg::TX_IDLE || n_tx_phase >= u8n1_pkg::TX_STOP) begin
            n_res.line_out = 1'b1;
        end else if (n_tx_phase == u8n1_pkg::TX_START) begin
            n_res.line_out = 1'b0;
        end else begin
            n_res.line_out = n_tx_shift[tx_idx[2:0]];
        end
        n_res.sender_busy = (n_tx_phase != u8n1_pkg::TX_IDLE);

        if (n_tx_phase != u8n1_pkg::TX_IDLE) begin
            tx_tick = {1'b0, n_tx_timer} + 1'b1;
            if (tx_tick >= {1'b0, r_tpb}) begin
                n_tx_timer = '0;
                n_tx_phase = (n_tx_phase >= u8n1_pkg::TX_STOP) ? u8n1_pkg::TX_IDLE
                                                                : n_tx_phase + 4'd1;
            end else begin
                n_tx_timer = tx_tick[u8n1_pkg::TPB_W-1:0];
            end
        end

        // ---------------- receiver ----------------
        n_rx_mode      = r_rx_mode;
        n_rx_timer     = r_rx_timer;
        n_rx_bit_count = r_rx_bit_count;
        n_rx_shift     = r_rx_shift;
        n_wait_count   = r_wait_count;
        rx_tick        = {1'b0, r_rx_timer} + 1'b1;
        rx_limit       = {2'b00, r_tpb[u8n1_pkg::TPB_W-1:1]};
        rx_idx         = r_rx_bit_count - 4'd1;

        if (i_arm_receive) begin
            n_rx_mode      = RX_WAIT;
            n_rx_timer     = '0;
            n_rx_bit_count = '0;
            n_rx_shift     = '0;
            n_wait_count   = '0;
            rx_tick        = {{u8n1_pkg::TPB_W{1'b0}}, 1'b1};
            rx_idx         = '1;
        end

        unique case (n_rx_mode)
            RX_WAIT: begin
                if (!i_line_in) begin
                    n_rx_mode      = RX_DATA;
                    n_rx_timer     = '0;
                    n_rx_bit_count = '0;
                    n_rx_shift     = '0;
                end else if (r_timeout != '0 && n_wait_count >= r_timeout) begin
                    n_res.got_byte  = 1'b1;
                    n_res.timed_out = 1'b1;
                    n_rx_mode       = RX_IDLE;
                end else if (n_wait_count != u8n1_pkg::WAIT_SAT) begin
                    n_wait_count = n_wait_count + 1'b1;
                end
            end
            RX_DATA: begin
                if (n_rx_bit_count == 4'd0) begin
                    // half-bit wait to centre the samples
                    if (rx_tick >= rx_limit) begin
                        n_rx_timer     = '0;
                        n_rx_bit_count = 4'd1;
                    end else begin
                        n_rx_timer = rx_tick[u8n1_pkg::TPB_W-1:0];
                    end
                end else if (rx_tick >= {1'b0, r_tpb}) begin
                    n_rx_timer                 = '0;
                    n_rx_shift[rx_idx[2:0]]    = i_line_in;
                    if (n_rx_bit_count >= 4'd8) begin
                        n_rx_bit_count = 4'd9;
                        n_rx_mode      = RX_STOP;
                    end else begin
                        n_rx_bit_count = n_rx_bit_count + 4'd1;
                    end
                end else begin
                    n_rx_timer = rx_tick[u8n1_pkg::TPB_W-1:0];
                end
            end
            RX_STOP: begin
                // stop bit is timed but not checked
                if (rx_tick >= {1'b0, r_tpb}) begin
                    n_res.got_byte      = 1'b1;
                    n_res.received_byte = n_rx_shift;
                    n_rx_mode           = RX_IDLE;
                    n_rx_timer          = '0;
                end else begin
                    n_rx_timer = rx_tick[u8n1_pkg::TPB_W-1:0];
                end
            end
            RX_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpb          <= u8n1_pkg::TPB_RESET;
            r_timeout      <= '0;
            r_tx_shift     <= '0;
            r_tx_phase     <= u8n1_pkg::TX_IDLE;
            r_tx_timer     <= '0;
            r_rx_mode      <= RX_IDLE;
            r_rx_timer     <= '0;
            r_rx_bit_count <= '0;
            r_rx_shift     <= '0;
            r_wait_count   <= '0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
            r_out          <= '0;
            r_skid         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    u8n1_pkg::CFG_TICKS_PER_BIT: r_tpb <= i_cfg_data[u8n1_pkg::TPB_W-1:0];
                    u8n1_pkg::CFG_START_TIMEOUT: r_timeout <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (in_take) begin
                r_tx_shift     <= n_tx_shift;
                r_tx_phase     <= n_tx_phase;
                r_tx_timer     <= n_tx_timer;
                r_rx_mode      <= n_rx_mode;
                r_rx_timer     <= n_rx_timer;
                r_rx_bit_count <= n_rx_bit_count;
                r_rx_shift     <= n_rx_shift;
                r_wait_count   <= n_wait_count;
            end

            // output register refills from skid first, then from the new transaction
            if (!r_out_valid || out_take) begin
                r_out_valid  <= r_skid_valid || in_take;
                r_skid_valid <= 1'b0;
                r_out        <= r_skid_valid ? r_skid : n_res;
            end else if (in_take) begin
                r_skid_valid <= 1'b1;
                r_skid       <= n_res;
            end
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_line_out      = r_out.line_out;
    assign o_sender_busy   = r_out.sender_busy;
    assign o_got_byte      = r_out.got_byte;
    assign o_received_byte = r_out.received_byte;
    assign o_timed_out     = r_out.timed_out;

endmodule

`default_nettype wire

>>> rtl/u8n1_checker.sv
// ---------------------------------------------------------------------------
// u8n1_checker
// Port-level checks of the 8N1 transceiver, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "uart_8n1_transceiver_defines.svh"

module u8n1_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_in_stall,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic                              o_line_out,
    input wire logic                              o_sender_busy,
    input wire logic                              o_got_byte,
    input wire logic [u8n1_pkg::BYTE_W-1:0]       o_received_byte,
    input wire logic                              o_timed_out
);

    // a stalled result stays offered
    `U8N1_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // receive fields are quiet unless a reception ends
    `U8N1_ASSERT_IMP(a_rx_quiet, o_out_valid && !o_got_byte, o_received_byte == '0 && !o_timed_out)

    // a timeout carries a zero byte
    `U8N1_ASSERT_IMP(a_tmo_zero, o_out_valid && o_timed_out, o_received_byte == '0)

    // line only drops low during a character
    `U8N1_ASSERT_IMP(a_tx_idle_high, o_out_valid && !o_line_out, o_sender_busy)

    // input is never stalled while no result is waiting
    `U8N1_ASSERT_IMP(a_no_idle_stall, !o_out_valid, !o_in_stall)

endmodule

bind uart_8n1_transceiver u8n1_checker u_u8n1_checker (.*);

`default_nettype wire
